// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the rotation matrix block.
// No dependencies; SYNTH removes every property.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/rrm_pkg.sv -----
// Types, constants and helpers for the axis-angle rotation matrix block.
// No dependencies.
package rrm_pkg;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        q30_t c;
        q30_t s;
        logic ident;
    } trig_t;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int AXIS_LAT          = 72;
    localparam int TRIG_LAT_BASE     = 8;
    localparam int PROD_LAT          = 3;

    localparam q30_t             ONE_Q30     = 32'sd1073741824;
    localparam logic [32:0]      DEG90       = 33'd5898240;
    localparam logic signed [33:0] ANG_OFFSET = 34'sd2170552320;
    localparam logic [26:0]      RAD_PER_DEG = 27'd74961321;
    localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic q30_t sat_q30(input logic signed [35:0] v);
        q30_t r;
        if (v > 36'sd1073741824) begin
            r = ONE_Q30;
        end else if (v < -36'sd1073741824) begin
            r = -ONE_Q30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/rrm_trig.sv -----
// Angle path: modulo reduction, degree to radian scaling, pipelined CORDIC.
// Depends on rrm_pkg.
module rrm_trig
    import rrm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] angle_deg,
    input  logic        axis_zero,
    output trig_t       trig
);

    localparam int DIV_BITS   = 10;
    localparam int DIV_STAGES = DIV_BITS / 2;

    logic signed [33:0] a_sum;
    logic [32:0] rm_reg [DIV_STAGES+1];
    logic [DIV_BITS-1:0] qt_reg [DIV_STAGES+1];
    logic az_reg [DIV_STAGES+1];

    assign a_sum = 34'(signed'(angle_deg)) + ANG_OFFSET;

    always_ff @(posedge aclk) begin
        if (en) begin
            rm_reg[0] <= a_sum[32:0];
            qt_reg[0] <= '0;
            az_reg[0] <= axis_zero;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        localparam int JH = DIV_BITS - 1 - 2 * g;
        localparam int JL = JH - 1;
        logic [33:0] r_mid, r_out;
        logic [DIV_BITS-1:0] q_out;
        always_comb begin
            q_out = qt_reg[g];
            r_mid = {1'b0, rm_reg[g]};
            if (r_mid >= (34'(DEG90) << JH)) begin
                r_mid = r_mid - (34'(DEG90) << JH);
                q_out[JH] = 1'b1;
            end
            r_out = r_mid;
            if (r_out >= (34'(DEG90) << JL)) begin
                r_out = r_out - (34'(DEG90) << JL);
                q_out[JL] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rm_reg[g+1] <= r_out[32:0];
                qt_reg[g+1] <= q_out;
                az_reg[g+1] <= az_reg[g];
            end
        end
    end

    logic [22:0] rem;
    logic [49:0] th_prod;
    logic [49:0] th_rnd;
    assign rem     = rm_reg[DIV_STAGES][22:0];
    assign th_prod = 50'(rem) * 50'(RAD_PER_DEG);
    assign th_rnd  = th_prod + 50'd131072;

    logic signed [33:0] cx_reg [CORDIC_STAGES+1];
    logic signed [33:0] cy_reg [CORDIC_STAGES+1];
    logic signed [33:0] cz_reg [CORDIC_STAGES+1];
    logic [1:0] qd_reg [CORDIC_STAGES+1];
    logic id_reg [CORDIC_STAGES+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= CORDIC_X0;
            cy_reg[0] <= '0;
            cz_reg[0] <= signed'({2'b00, th_rnd[49:18]});
            qd_reg[0] <= qt_reg[DIV_STAGES][1:0];
            id_reg[0] <= az_reg[DIV_STAGES] ||
                         (rem == '0 && qt_reg[DIV_STAGES][1:0] == 2'd0);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [33:0] AT = signed'({2'b00, atan_q30(i)});
        logic signed [33:0] x_next, y_next, z_next;
        always_comb begin
            if (!cz_reg[i][33]) begin
                x_next = cx_reg[i] - (cy_reg[i] >>> i);
                y_next = cy_reg[i] + (cx_reg[i] >>> i);
                z_next = cz_reg[i] - AT;
            end else begin
                x_next = cx_reg[i] + (cy_reg[i] >>> i);
                y_next = cy_reg[i] - (cx_reg[i] >>> i);
                z_next = cz_reg[i] + AT;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[i+1] <= x_next;
                cy_reg[i+1] <= y_next;
                cz_reg[i+1] <= z_next;
                qd_reg[i+1] <= qd_reg[i];
                id_reg[i+1] <= id_reg[i];
            end
        end
    end

    logic signed [33:0] xf, yf, c_pre, s_pre;
    trig_t trig_reg, trig_next;

    assign xf = cx_reg[CORDIC_STAGES];
    assign yf = cy_reg[CORDIC_STAGES];

    always_comb begin
        case (qd_reg[CORDIC_STAGES])
            2'd0: begin
                c_pre = xf;
                s_pre = yf;
            end
            2'd1: begin
                c_pre = -yf;
                s_pre = xf;
            end
            2'd2: begin
                c_pre = -xf;
                s_pre = -yf;
            end
            default: begin
                c_pre = yf;
                s_pre = -xf;
            end
        endcase
        trig_next.c     = sat_q30(36'(c_pre));
        trig_next.s     = sat_q30(36'(s_pre));
        trig_next.ident = id_reg[CORDIC_STAGES];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// ----- rtl/rrm_axis.sv -----
// Axis path: normalizing shift, squared norm, pipelined square root and
// pipelined restoring dividers giving the unit axis. Depends on rrm_pkg.
module rrm_axis
    import rrm_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] axis_x,
    input  logic [31:0] axis_y,
    input  logic [31:0] axis_z,
    output q30_t        u_x,
    output q30_t        u_y,
    output q30_t        u_z
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    logic [31:0] v_in [3];
    assign v_in[0] = axis_x;
    assign v_in[1] = axis_y;
    assign v_in[2] = axis_z;

    logic [31:0] mag1_reg [3];
    logic        neg1_reg [3];
    logic [31:0] mag2_reg [3];
    logic        neg2_reg [3];
    logic [31:0] mag3_reg [3];
    logic        neg3_reg [3];
    logic [31:0] sh4_reg [3];
    logic        neg4_reg [3];
    logic [63:0] sq5_reg [3];
    logic [31:0] sh5_reg [3];
    logic        neg5_reg [3];
    logic [3:0]  nz2_reg;
    logic [2:0]  lz2_reg [4];
    logic [4:0]  l3_reg;

    logic [31:0] orw;
    logic [3:0]  nz_next;
    logic [2:0]  lz_next [4];
    logic [5:0]  lzc;
    logic [4:0]  l_next;

    always_comb begin
        orw = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        for (int b = 0; b < 4; b++) begin
            nz_next[b] = |orw[8*b +: 8];
            lz_next[b] = 3'd7;
            for (int k = 0; k < 8; k++) begin
                if (orw[8*b + k]) begin
                    lz_next[b] = 3'(7 - k);
                end
            end
        end
    end

    always_comb begin
        lzc = 6'd32;
        for (int b = 0; b < 4; b++) begin
            if (nz2_reg[b]) begin
                lzc = 6'(8 * (3 - b)) + 6'(lz2_reg[b]);
            end
        end
        l_next = (lzc == 6'd0) ? 5'd0 : 5'(lzc - 6'd1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag1_reg[i] <= v_in[i][31] ? (32'd0 - v_in[i]) : v_in[i];
                neg1_reg[i] <= v_in[i][31];
                mag2_reg[i] <= mag1_reg[i];
                neg2_reg[i] <= neg1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                neg3_reg[i] <= neg2_reg[i];
                sh4_reg[i]  <= mag3_reg[i] << l3_reg;
                neg4_reg[i] <= neg3_reg[i];
                sq5_reg[i]  <= 64'(sh4_reg[i]) * 64'(sh4_reg[i]);
                sh5_reg[i]  <= sh4_reg[i];
                neg5_reg[i] <= neg4_reg[i];
            end
            nz2_reg <= nz_next;
            for (int b = 0; b < 4; b++) begin
                lz2_reg[b] <= lz_next[b];
            end
            l3_reg <= l_next;
        end
    end

    logic [63:0] sn_reg  [SQ_STEPS+1];
    logic [63:0] sr_reg  [SQ_STEPS+1];
    logic [31:0] ssh_reg [SQ_STEPS+1][3];
    logic        sng_reg [SQ_STEPS+1][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            sn_reg[0] <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            sr_reg[0] <= '0;
            for (int i = 0; i < 3; i++) begin
                ssh_reg[0][i] <= sh5_reg[i];
                sng_reg[0][i] <= neg5_reg[i];
            end
        end
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] trial, n_next, r_next;
        always_comb begin
            trial = sr_reg[g] + BIT;
            if (sn_reg[g] >= trial) begin
                n_next = sn_reg[g] - trial;
                r_next = (sr_reg[g] >> 1) + BIT;
            end else begin
                n_next = sn_reg[g];
                r_next = sr_reg[g] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sn_reg[g+1] <= n_next;
                sr_reg[g+1] <= r_next;
                for (int i = 0; i < 3; i++) begin
                    ssh_reg[g+1][i] <= ssh_reg[g][i];
                    sng_reg[g+1][i] <= sng_reg[g][i];
                end
            end
        end
    end

    logic [31:0] norm;
    assign norm = sr_reg[SQ_STEPS][31:0];

    logic [63:0] dn_reg [DIV_STEPS+1][3];
    logic [31:0] dq_reg [DIV_STEPS+1][3];
    logic        dg_reg [DIV_STEPS+1][3];
    logic [31:0] dd_reg [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg[0] <= norm;
            for (int i = 0; i < 3; i++) begin
                dn_reg[0][i] <= {2'b00, ssh_reg[SQ_STEPS][i], 30'd0} +
                                64'(norm >> 1);
                dq_reg[0][i] <= '0;
                dg_reg[0][i] <= sng_reg[SQ_STEPS][i];
            end
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        localparam int J = DIV_STEPS - 1 - g;
        logic [63:0] dsh;
        logic [63:0] n_next [3];
        logic [31:0] q_next [3];
        assign dsh = 64'(dd_reg[g]) << J;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_next[i] = dn_reg[g][i];
                q_next[i] = dq_reg[g][i];
                if (dn_reg[g][i] >= dsh) begin
                    n_next[i]    = dn_reg[g][i] - dsh;
                    q_next[i][J] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dd_reg[g+1] <= dd_reg[g];
                for (int i = 0; i < 3; i++) begin
                    dn_reg[g+1][i] <= n_next[i];
                    dq_reg[g+1][i] <= q_next[i];
                    dg_reg[g+1][i] <= dg_reg[g][i];
                end
            end
        end
    end

    q30_t u_reg [3];
    q30_t u_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dq_reg[DIV_STEPS][i] > 32'd1073741824) begin
                u_next[i] = ONE_Q30;
            end else begin
                u_next[i] = signed'(dq_reg[DIV_STEPS][i]);
            end
            if (dg_reg[DIV_STEPS][i]) begin
                u_next[i] = -u_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= u_next[i];
            end
        end
    end

    assign u_x = u_reg[0];
    assign u_y = u_reg[1];
    assign u_z = u_reg[2];

endmodule

// ----- rtl/axis_angle_rotation_matrix.sv -----
// Channel  Ports                                  Dir  Payload
// input    s_valid s_ready s_angle_deg s_axis_*   in   angle and axis, Q16.16
// result   m_valid m_ready m_r0c0 .. m_r2c2       out  rotation matrix, Q2.30
//
// One beat per cycle in, one per cycle out while m_ready does not stall; the
// axis path (32 square root steps and 32 divider steps) is the longer path.
// The angle path (reduction, CORDIC and output register) is delayed to meet the axis path.
// A stall on m_ready freezes the whole pipeline; no output skid is lost.
// Reset (aresetn, synchronous) clears only the valid line.
// Top level; depends on rrm_pkg, rrm_trig, rrm_axis and assert_macros.svh.
`include "assert_macros.svh"
module axis_angle_rotation_matrix
    import rrm_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_angle_deg,
    input  logic [31:0] s_axis_x,
    input  logic [31:0] s_axis_y,
    input  logic [31:0] s_axis_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_r0c0,
    output logic [31:0] m_r0c1,
    output logic [31:0] m_r0c2,
    output logic [31:0] m_r1c0,
    output logic [31:0] m_r1c1,
    output logic [31:0] m_r1c2,
    output logic [31:0] m_r2c0,
    output logic [31:0] m_r2c1,
    output logic [31:0] m_r2c2
);

    localparam int DLY       = AXIS_LAT - (CORDIC_STAGES + TRIG_LAT_BASE);
    localparam int TOTAL_LAT = AXIS_LAT + PROD_LAT;

    function automatic logic signed [32:0] pmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] prod;
        prod = a * b;
        prod = prod + 66'sd536870912;
        return 33'(prod >>> 30);
    endfunction

    logic en;
    logic axis_zero;
    logic vld_reg [TOTAL_LAT];

    assign en        = !vld_reg[TOTAL_LAT-1] || m_ready;
    assign s_ready   = en && aresetn;
    assign m_valid   = vld_reg[TOTAL_LAT-1];
    assign axis_zero = (s_axis_x == '0) && (s_axis_y == '0) && (s_axis_z == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    trig_t trig;
    q30_t  u [3];

    rrm_trig #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_trig (
        .aclk      (aclk),
        .en        (en),
        .angle_deg (s_angle_deg),
        .axis_zero (axis_zero),
        .trig      (trig)
    );

    rrm_axis u_axis (
        .aclk   (aclk),
        .en     (en),
        .axis_x (s_axis_x),
        .axis_y (s_axis_y),
        .axis_z (s_axis_z),
        .u_x    (u[0]),
        .u_y    (u[1]),
        .u_z    (u[2])
    );

    trig_t trig_dly_reg [DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_dly_reg[0] <= trig;
            for (int i = 1; i < DLY; i++) begin
                trig_dly_reg[i] <= trig_dly_reg[i-1];
            end
        end
    end

    trig_t tr;
    assign tr = trig_dly_reg[DLY-1];

    // pair order: xx, yy, zz, xy, xz, yz
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic signed [32:0] puu_reg [6];
    logic signed [32:0] psu_reg [3];
    logic signed [32:0] k_reg;
    q30_t               c1_reg;
    logic               id1_reg;

    logic signed [32:0] pk_reg [6];
    logic signed [32:0] psu2_reg [3];
    q30_t               c2_reg;
    logic               id2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 6; p++) begin
                puu_reg[p] <= pmul(33'(u[PA[p]]), 33'(u[PB[p]]));
            end
            for (int i = 0; i < 3; i++) begin
                psu_reg[i] <= pmul(33'(tr.s), 33'(u[i]));
            end
            k_reg   <= 33'(ONE_Q30) - 33'(tr.c);
            c1_reg  <= tr.c;
            id1_reg <= tr.ident;

            for (int p = 0; p < 6; p++) begin
                pk_reg[p] <= pmul(k_reg, puu_reg[p]);
            end
            for (int i = 0; i < 3; i++) begin
                psu2_reg[i] <= psu_reg[i];
            end
            c2_reg  <= c1_reg;
            id2_reg <= id1_reg;
        end
    end

    q30_t m_next [9];
    q30_t m_reg  [9];

    always_comb begin
        m_next[0] = sat_q30(36'(c2_reg) + 36'(pk_reg[0]));
        m_next[4] = sat_q30(36'(c2_reg) + 36'(pk_reg[1]));
        m_next[8] = sat_q30(36'(c2_reg) + 36'(pk_reg[2]));
        m_next[1] = sat_q30(36'(pk_reg[3]) - 36'(psu2_reg[2]));
        m_next[3] = sat_q30(36'(pk_reg[3]) + 36'(psu2_reg[2]));
        m_next[2] = sat_q30(36'(pk_reg[4]) + 36'(psu2_reg[1]));
        m_next[6] = sat_q30(36'(pk_reg[4]) - 36'(psu2_reg[1]));
        m_next[5] = sat_q30(36'(pk_reg[5]) - 36'(psu2_reg[0]));
        m_next[7] = sat_q30(36'(pk_reg[5]) + 36'(psu2_reg[0]));
        if (id2_reg) begin
            for (int i = 0; i < 9; i++) begin
                m_next[i] = '0;
            end
            m_next[0] = ONE_Q30;
            m_next[4] = ONE_Q30;
            m_next[8] = ONE_Q30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                m_reg[i] <= m_next[i];
            end
        end
    end

    assign m_r0c0 = m_reg[0];
    assign m_r0c1 = m_reg[1];
    assign m_r0c2 = m_reg[2];
    assign m_r1c0 = m_reg[3];
    assign m_r1c1 = m_reg[4];
    assign m_r1c2 = m_reg[5];
    assign m_r2c0 = m_reg[6];
    assign m_r2c1 = m_reg[7];
    assign m_r2c2 = m_reg[8];

    `ASSERT_IMPL(a_diag_range, aclk, aresetn, m_valid, ($signed(m_r0c0) <= ONE_Q30) && ($signed(m_r0c0) >= -ONE_Q30))
    `ASSERT_IMPL(a_off_range, aclk, aresetn, m_valid, ($signed(m_r1c2) <= ONE_Q30) && ($signed(m_r1c2) >= -ONE_Q30))
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, !en, $stable(vld_reg[TOTAL_LAT-1]) && $stable(m_r2c2))
    `ASSERT_NEXT(a_ident_out, aclk, aresetn, en && id2_reg, m_reg[0] == ONE_Q30 && m_reg[1] == '0)

endmodule
